FILE: rtl/vfv_pkg.sv
// Shared types and constants of the voxel face visibility unit.
`default_nettype none

package vfv_pkg;

  localparam int unsigned COORD_W  = 4;
  localparam int unsigned NCOORD_W = COORD_W + 1;
  localparam int unsigned OTYPE_W  = 8;
  localparam int unsigned MASK_W   = 6;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [2:0] FACE_XN   = 3'd0;
  localparam logic [2:0] FACE_XP   = 3'd1;
  localparam logic [2:0] FACE_YN   = 3'd2;
  localparam logic [2:0] FACE_YP   = 3'd3;
  localparam logic [2:0] FACE_ZN   = 3'd4;
  localparam logic [2:0] FACE_ZP   = 3'd5;
  localparam logic [2:0] NUM_FACES = 3'd6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_EMPTY_TYPE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WRITE,
    ST_FACE,
    ST_DONE
  } vfv_state_e;

endpackage

`default_nettype wire

FILE: rtl/vfv_if.sv
// Valid/ready channel interfaces for voxel operations and their results.
`default_nettype none

interface vfv_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [vfv_pkg::COORD_W-1:0]  x_coord;
  logic [vfv_pkg::COORD_W-1:0]  y_coord;
  logic [vfv_pkg::COORD_W-1:0]  z_coord;
  logic [vfv_pkg::OTYPE_W-1:0]  new_type;

  modport source (output valid, opcode, x_coord, y_coord, z_coord, new_type, input ready);
  modport sink   (input valid, opcode, x_coord, y_coord, z_coord, new_type, output ready);
endinterface

interface vfv_out_if;
  logic                         valid;
  logic                         ready;
  logic                         changed;
  logic [vfv_pkg::OTYPE_W-1:0]  block_type;
  logic                         is_empty;
  logic [vfv_pkg::MASK_W-1:0]   face_mask;

  modport source (output valid, changed, block_type, is_empty, face_mask, input ready);
  modport sink   (input valid, changed, block_type, is_empty, face_mask, output ready);
endinterface

`default_nettype wire

FILE: rtl/vfv_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module vfv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/voxel_face_visibility_unit.sv
// Top level of the voxel face visibility unit: sequencer, datapath and store.
//   in_i carries one operation per transfer: a write stores new_type at
//   (x,y,z) and returns the old type and a changed flag; a query returns the
//   stored type, an empty flag and the six-bit visible-face mask
//   (-x,+x,-y,+y,-z,+z from bit 0). out_o carries one result per operation.
//   The APB port holds empty_type at byte address 0; pready is tied high.
//   All voxel reads and writes share one single-ported store with a
//   registered read, and one comparator judges each word read back against
//   empty_type; a write also compares its old word with the new type. A
//   query reads the voxel, then its six neighbours one per cycle with the
//   compare of each word in the cycle after its read; an empty voxel skips
//   the neighbours. A write reads the old type and always writes the new one
//   back. An out-of-range coordinate skips the store. The result lands in
//   the output register at the end of the operation.
//   Reset clears the sequencer, the output valid and empty_type; the store
//   keeps whatever it held and must be written before it is queried. A
//   finished result waits in the output register; the next operation is
//   still taken and processed, and only its own completion holds until the
//   receiver drains the previous result.
`default_nettype none

module voxel_face_visibility_unit #(
  parameter int unsigned SIDE      = 16,
  parameter int unsigned TYPE_BITS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  vfv_in_if.sink                           in_i,
  vfv_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vfv_pkg::APB_AW-1:0]  paddr,
  input  wire logic [vfv_pkg::APB_DW-1:0]  pwdata,
  output logic      [vfv_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  import vfv_pkg::*;

  localparam int unsigned SQ    = SIDE * SIDE;
  localparam int unsigned DEPTH = SQ * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LAST  = SIDE - 1;

  // Flattened address, x-major then y then z
  function automatic logic [AW-1:0] addr_of(input logic [NCOORD_W-1:0] x,
                                            input logic [NCOORD_W-1:0] y,
                                            input logic [NCOORD_W-1:0] z);
    logic [31:0] a;
    a = 32'(x) * SQ + 32'(y) * SIDE + 32'(z);
    return a[AW-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [OTYPE_W-1:0] empty_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[APB_AW-1] == REG_EMPTY_TYPE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= '0;
    end else if (cfg_wr) begin
      empty_q <= pwdata[OTYPE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1] == REG_EMPTY_TYPE) begin
      prdata = {{(APB_DW-OTYPE_W){1'b0}}, empty_q};
    end
  end

  // ---------------------------------------------------------------- state
  vfv_state_e state_q, state_d;

  logic                 op_q;
  logic [COORD_W-1:0]   x_q, y_q, z_q;
  logic [TYPE_BITS-1:0] nt_q;
  logic [2:0]           face_q;
  logic                 changed_q;
  logic [OTYPE_W-1:0]   btype_q;
  logic                 empty_res_q;
  logic [MASK_W-1:0]    mask_q;

  logic                 out_valid_q;
  logic                 out_changed_q;
  logic [OTYPE_W-1:0]   out_btype_q;
  logic                 out_empty_q;
  logic [MASK_W-1:0]    out_mask_q;

  // Cut incoming types to the store width
  logic [TYPE_BITS+OTYPE_W-1:0] nt_wide, empty_wide, rd_wide;
  logic [TYPE_BITS-1:0]         nt_in, empty_tb, rdata;
  logic [OTYPE_W-1:0]           rd_type;

  assign nt_wide    = {{TYPE_BITS{1'b0}}, in_i.new_type};
  assign empty_wide = {{TYPE_BITS{1'b0}}, empty_q};
  assign nt_in      = nt_wide[TYPE_BITS-1:0];
  assign empty_tb   = empty_wide[TYPE_BITS-1:0];
  assign rd_wide    = {{OTYPE_W{1'b0}}, rdata};
  assign rd_type    = rd_wide[OTYPE_W-1:0];

  logic accept, in_range, rd_empty, out_load;

  assign accept   = in_i.valid & in_i.ready;
  assign in_range = (32'(in_i.x_coord) < SIDE) && (32'(in_i.y_coord) < SIDE) &&
                    (32'(in_i.z_coord) < SIDE);
  // The shared comparator: every word read back is judged against empty_type
  assign rd_empty = (rdata == empty_tb);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // Chunk boundary flags per face
  logic [MASK_W-1:0] bnd;
  assign bnd = {32'(z_q) == LAST, z_q == '0,
                32'(y_q) == LAST, y_q == '0,
                32'(x_q) == LAST, x_q == '0};

  // Face judged this cycle lags the face being read by one
  logic [2:0] ev_face;
  assign ev_face = face_q - 3'd1;

  // ---------------------------------------------------------------- neighbour address
  logic [NCOORD_W-1:0] cx, cy, cz, nx, ny, nz;

  assign cx = {1'b0, x_q};
  assign cy = {1'b0, y_q};
  assign cz = {1'b0, z_q};

  always_comb begin
    nx = cx;
    ny = cy;
    nz = cz;
    case (face_q)
      FACE_XN: if (!bnd[FACE_XN]) nx = cx - NCOORD_W'(1);
      FACE_XP: if (!bnd[FACE_XP]) nx = cx + NCOORD_W'(1);
      FACE_YN: if (!bnd[FACE_YN]) ny = cy - NCOORD_W'(1);
      FACE_YP: if (!bnd[FACE_YP]) ny = cy + NCOORD_W'(1);
      FACE_ZN: if (!bnd[FACE_ZN]) nz = cz - NCOORD_W'(1);
      FACE_ZP: if (!bnd[FACE_ZP]) nz = cz + NCOORD_W'(1);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- store
  logic          ram_we;
  logic [AW-1:0] ram_addr;

  vfv_ram #(
    .WIDTH (TYPE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (nt_q),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = in_range ? ST_LOOK : ST_DONE;
        end
      end
      ST_LOOK: begin
        // A write always stores its type back, so the path never depends
        // on the old word, which may not have been written yet
        if (op_q == OP_WRITE) begin
          state_d = ST_WRITE;
        end else begin
          state_d = rd_empty ? ST_DONE : ST_FACE;
        end
      end
      ST_WRITE: state_d = ST_DONE;
      ST_FACE: begin
        if (face_q == NUM_FACES) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs: the store is read at the incoming voxel on transfer,
  // at the neighbours while scanning faces, and written once per write
  always_comb begin
    in_i.ready = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = addr_of(cx, cy, cz);
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_addr   = addr_of({1'b0, in_i.x_coord}, {1'b0, in_i.y_coord},
                             {1'b0, in_i.z_coord});
      end
      ST_WRITE: ram_we = 1'b1;
      ST_FACE:  ram_addr = addr_of(nx, ny, nz);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      face_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        face_q <= '0;
      end else if (state_q == ST_FACE) begin
        face_q <= face_q + 3'd1;
      end
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= in_i.opcode;
      x_q         <= in_i.x_coord;
      y_q         <= in_i.y_coord;
      z_q         <= in_i.z_coord;
      nt_q        <= nt_in;
      changed_q   <= 1'b0;
      btype_q     <= '0;
      empty_res_q <= 1'b0;
      mask_q      <= '0;
    end else if (state_q == ST_LOOK) begin
      btype_q <= rd_type;
      if (op_q == OP_WRITE) begin
        changed_q <= (rdata != nt_q);
      end else begin
        empty_res_q <= rd_empty;
      end
    end else if (state_q == ST_FACE && face_q != '0) begin
      // Mark the face whose neighbour word arrived this cycle
      if (bnd[ev_face] || rd_empty) begin
        mask_q[ev_face] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_changed_q <= changed_q;
      out_btype_q   <= btype_q;
      out_empty_q   <= empty_res_q;
      out_mask_q    <= mask_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.changed    = out_changed_q;
  assign out_o.block_type = out_btype_q;
  assign out_o.is_empty   = out_empty_q;
  assign out_o.face_mask  = out_mask_q;

endmodule

`default_nettype wire

FILE: rtl/vfv_checker.sv
// Port-level checks of the voxel face visibility unit and their binding.
`default_nettype none

module vfv_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        out_changed_i,
  input wire logic [vfv_pkg::OTYPE_W-1:0] out_block_type_i,
  input wire logic                        out_is_empty_i,
  input wire logic [vfv_pkg::MASK_W-1:0]  out_face_mask_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_changed_i) && $stable(out_block_type_i)
                                    && $stable(out_is_empty_i) && $stable(out_face_mask_i))
    else $error("stalled result changed");

  // An empty voxel shows no faces and is never a write
  a_empty_no_faces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_is_empty_i |-> out_face_mask_i == '0 && !out_changed_i)
    else $error("empty voxel with faces or change flag");

  // A changed write result carries neither empty flag nor faces
  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_changed_i |-> !out_is_empty_i && out_face_mask_i == '0)
    else $error("write result with query fields set");

  // One item at a time: the sequencer leaves idle on every input transfer
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

endmodule

bind voxel_face_visibility_unit vfv_checker u_vfv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_changed_i    (out_o.changed),
  .out_block_type_i (out_o.block_type),
  .out_is_empty_i   (out_o.is_empty),
  .out_face_mask_i  (out_o.face_mask)
);

`default_nettype wire
